// ===== sv/modbus_rtu_read_response_checker_defines.svh =====
// Assertion macros used by the checker file mrc_checker.sv.
// Each macro expands to one labeled concurrent assertion on the aclk domain,
// disabled while aresetn is low.
`ifndef MODBUS_RTU_READ_RESPONSE_CHECKER_DEFINES_SVH
`define MODBUS_RTU_READ_RESPONSE_CHECKER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mrc_pkg.sv =====
package mrc_pkg;

    // CRC-16 start value and reflected polynomial
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Function code flag that marks an exception response
    localparam logic [7:0] EXC_FLAG = 8'h80;

    // Result word kinds
    localparam logic KIND_REG    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_CRC       = 3'd2,
        ST_EXCEPTION = 3'd3,
        ST_BAD_FUNC  = 3'd4,
        ST_BAD_COUNT = 3'd5,
        ST_ODD_COUNT = 3'd6
    } status_t;

    // One queue entry: what one accepted byte produced
    typedef struct packed {
        logic        has_reg;
        logic [6:0]  reg_index;
        logic [15:0] reg_value;
        logic        has_status;
        status_t     status;
        logic [7:0]  exc_code;
    } entry_t;

    // Byte-wide CRC-16 step, unrolled over the eight bits
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/modbus_rtu_read_response_checker.sv =====
// Modbus RTU read-registers response checker.
// Input channel (s_): one frame byte per word, s_end_of_frame on the last byte.
// Output channel (m_): register words (m_kind 0) with index and big-endian value
// as soon as each data pair completes, and one status word (m_kind 1, m_last 1)
// per frame carrying the check result and any exception code.
// Config channel (cfg_): writes the expected function code; always ready.
// Throughput: one byte per cycle while the queue is not full; the byte-wide CRC
// step and the frame checks finish in the cycle the byte is accepted.
// A result word is written into the queue when its byte is accepted and moves
// from there into the output register when the queue and output are free; a
// byte that completes a pair and ends the frame gives two words from one queue
// entry, the register word and then the status word.
// A queue of QUEUE_DEPTH entries sits between the byte front end and the
// output stage; when the receiver stalls the queue fills and s_ready drops.
// Reset (aresetn low, synchronous) clears the frame state, the queue and the
// output word, and sets the expected function code to 3.
module modbus_rtu_read_response_checker #(
    parameter int MAX_FRAME   = 260,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_end_of_frame,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [6:0]  m_reg_index,
    output logic [15:0] m_reg_value,
    output logic [2:0]  m_status,
    output logic [7:0]  m_exception_code,
    output logic        m_last
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_empty;
    mrc_pkg::entry_t q_entry;
    mrc_pkg::entry_t q_head;

    assign cfg_ready = 1'b1;

    mrc_front #(
        .MAX_FRAME(MAX_FRAME)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_in     (s_byte_in),
        .s_end_of_frame(s_end_of_frame),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    mrc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(q_entry),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    mrc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_reg_index     (m_reg_index),
        .m_reg_value     (m_reg_value),
        .m_status        (m_status),
        .m_exception_code(m_exception_code),
        .m_last          (m_last)
    );

endmodule

// ===== sv/mrc_front.sv =====
module mrc_front #(
    parameter int MAX_FRAME = 260
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [7:0]       cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_byte_in,
    input  logic             s_end_of_frame,
    input  logic             q_full,
    output logic             q_push,
    output mrc_pkg::entry_t  q_entry
);

    localparam int PosW = $clog2(MAX_FRAME + 1);
    localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME);

    logic [7:0]      exp_func_reg, exp_func_next;
    logic [7:0]      d0_reg, d0_next;
    logic [7:0]      d1_reg, d1_next;
    logic [15:0]     crc_reg, crc_next;
    logic [PosW-1:0] pos_reg, pos_next;
    logic [7:0]      func_reg, func_next;
    logic [7:0]      count_reg, count_next;
    logic [7:0]      high_reg, high_next;
    logic [6:0]      reg_cnt_reg, reg_cnt_next;

    logic             accept;
    logic [9:0]       pos_w;
    logic [9:0]       count_w;
    logic [15:0]      crc_cur;
    logic [15:0]      rx_crc;
    logic             in_window;
    logic             is_reg;
    mrc_pkg::status_t status;
    logic [7:0]       exc_code;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    // Classify the byte and check the frame on its last byte
    always_comb begin
        pos_w     = 10'(pos_reg);
        count_w   = 10'(count_reg);
        crc_cur   = (pos_reg >= PosW'(2)) ? mrc_pkg::crc_byte(crc_reg, d1_reg) : crc_reg;
        rx_crc    = {s_byte_in, d0_reg};
        in_window = pos_reg < PosMax;
        is_reg    = in_window && (pos_w >= 10'd4) && !pos_reg[0]
                    && (pos_w <= count_w + 10'd2);

        exc_code = 8'h00;
        if (pos_w < 10'd4) begin
            status = mrc_pkg::ST_SHORT;
        end else if (crc_cur != rx_crc) begin
            status = mrc_pkg::ST_CRC;
        end else if (func_reg == (exp_func_reg | mrc_pkg::EXC_FLAG)) begin
            status   = mrc_pkg::ST_EXCEPTION;
            exc_code = count_reg;
        end else if (func_reg != exp_func_reg) begin
            status = mrc_pkg::ST_BAD_FUNC;
        end else if ((count_reg == 8'h00) || !in_window || (pos_w != count_w + 10'd4)) begin
            status = mrc_pkg::ST_BAD_COUNT;
        end else if (count_reg[0]) begin
            status = mrc_pkg::ST_ODD_COUNT;
        end else begin
            status = mrc_pkg::ST_OK;
        end
    end

    // Post a queue entry when the byte yields a register or ends the frame
    always_comb begin
        q_push             = accept && (is_reg || s_end_of_frame);
        q_entry.has_reg    = is_reg;
        q_entry.reg_index  = reg_cnt_reg;
        q_entry.reg_value  = {high_reg, s_byte_in};
        q_entry.has_status = s_end_of_frame;
        q_entry.status     = status;
        q_entry.exc_code   = exc_code;
    end

    // Advance the frame state
    always_comb begin
        exp_func_next = cfg_valid ? cfg_data : exp_func_reg;
        d0_next       = d0_reg;
        d1_next       = d1_reg;
        crc_next      = crc_reg;
        pos_next      = pos_reg;
        func_next     = func_reg;
        count_next    = count_reg;
        high_next     = high_reg;
        reg_cnt_next  = reg_cnt_reg;
        if (accept) begin
            if (s_end_of_frame) begin
                d0_next      = 8'h00;
                d1_next      = 8'h00;
                crc_next     = mrc_pkg::CRC_INIT;
                pos_next     = '0;
                func_next    = 8'h00;
                count_next   = 8'h00;
                high_next    = 8'h00;
                reg_cnt_next = 7'd0;
            end else begin
                d1_next  = d0_reg;
                d0_next  = s_byte_in;
                crc_next = crc_cur;
                if (in_window) begin
                    pos_next = pos_reg + PosW'(1);
                    if (pos_reg == PosW'(1)) begin
                        func_next = s_byte_in;
                    end else if (pos_reg == PosW'(2)) begin
                        count_next = s_byte_in;
                    end else if (pos_reg[0]) begin
                        high_next = s_byte_in;
                    end
                end
                if (is_reg) begin
                    reg_cnt_next = reg_cnt_reg + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_func_reg <= 8'd3;
            d0_reg       <= 8'h00;
            d1_reg       <= 8'h00;
            crc_reg      <= mrc_pkg::CRC_INIT;
            pos_reg      <= '0;
            func_reg     <= 8'h00;
            count_reg    <= 8'h00;
            high_reg     <= 8'h00;
            reg_cnt_reg  <= 7'd0;
        end else begin
            exp_func_reg <= exp_func_next;
            d0_reg       <= d0_next;
            d1_reg       <= d1_next;
            crc_reg      <= crc_next;
            pos_reg      <= pos_next;
            func_reg     <= func_next;
            count_reg    <= count_next;
            high_reg     <= high_next;
            reg_cnt_reg  <= reg_cnt_next;
        end
    end

endmodule

// ===== sv/mrc_queue.sv =====
module mrc_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mrc_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output mrc_pkg::entry_t head
);

    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW  = $clog2(DEPTH + 1);

    mrc_pkg::entry_t  mem_reg [DEPTH];
    logic [AddrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AddrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == CntW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AddrW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AddrW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CntW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the entry
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/mrc_back.sv =====
module mrc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_empty,
    input  mrc_pkg::entry_t q_head,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_kind,
    output logic [6:0]      m_reg_index,
    output logic [15:0]     m_reg_value,
    output logic [2:0]      m_status,
    output logic [7:0]      m_exception_code,
    output logic            m_last
);

    logic             valid_reg, valid_next;
    logic             kind_reg, kind_next;
    logic [6:0]       idx_reg, idx_next;
    logic [15:0]      val_reg, val_next;
    mrc_pkg::status_t status_reg, status_next;
    logic [7:0]       exc_reg, exc_next;
    logic             last_reg, last_next;
    logic             hold_reg, hold_next;
    mrc_pkg::status_t hold_status_reg, hold_status_next;
    logic [7:0]       hold_exc_reg, hold_exc_next;
    logic             load;

    // Load the output word when it is empty or being taken
    always_comb begin
        load             = !valid_reg || m_ready;
        q_pop            = load && !hold_reg && !q_empty;
        valid_next       = valid_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        val_next         = val_reg;
        status_next      = status_reg;
        exc_next         = exc_reg;
        last_next        = last_reg;
        hold_next        = hold_reg;
        hold_status_next = hold_status_reg;
        hold_exc_next    = hold_exc_reg;
        if (load) begin
            if (hold_reg) begin
                // emit the status that followed a register on the last byte
                valid_next  = 1'b1;
                kind_next   = mrc_pkg::KIND_STATUS;
                idx_next    = 7'd0;
                val_next    = 16'h0000;
                status_next = hold_status_reg;
                exc_next    = hold_exc_reg;
                last_next   = 1'b1;
                hold_next   = 1'b0;
            end else if (!q_empty) begin
                valid_next = 1'b1;
                if (q_head.has_reg) begin
                    kind_next        = mrc_pkg::KIND_REG;
                    idx_next         = q_head.reg_index;
                    val_next         = q_head.reg_value;
                    status_next      = mrc_pkg::ST_OK;
                    exc_next         = 8'h00;
                    last_next        = 1'b0;
                    hold_next        = q_head.has_status;
                    hold_status_next = q_head.status;
                    hold_exc_next    = q_head.exc_code;
                end else begin
                    kind_next   = mrc_pkg::KIND_STATUS;
                    idx_next    = 7'd0;
                    val_next    = 16'h0000;
                    status_next = q_head.status;
                    exc_next    = q_head.exc_code;
                    last_next   = 1'b1;
                end
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hold_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            hold_reg  <= hold_next;
        end
    end

    // Hold payload without reset
    always_ff @(posedge aclk) begin
        kind_reg        <= kind_next;
        idx_reg         <= idx_next;
        val_reg         <= val_next;
        status_reg      <= status_next;
        exc_reg         <= exc_next;
        last_reg        <= last_next;
        hold_status_reg <= hold_status_next;
        hold_exc_reg    <= hold_exc_next;
    end

    assign m_valid          = valid_reg;
    assign m_kind           = kind_reg;
    assign m_reg_index      = idx_reg;
    assign m_reg_value      = val_reg;
    assign m_status         = 3'(status_reg);
    assign m_exception_code = exc_reg;
    assign m_last           = last_reg;

endmodule

// ===== sv/mrc_checker.sv =====
`include "modbus_rtu_read_response_checker_defines.svh"

module mrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic [15:0] m_reg_value,
    input logic [2:0]  m_status,
    input logic [7:0]  m_exception_code,
    input logic        m_last
);

    // A stalled word stays put
    `MRC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_reg_value) && $stable(m_status), "output word changed while stalled")

    // Only status words end a frame
    `MRC_ASSERT_SAME(a_last_kind, m_valid, m_last == m_kind, "last flag disagrees with word kind")

    // Register words carry no status
    `MRC_ASSERT_SAME(a_reg_clean, m_valid && (m_kind == mrc_pkg::KIND_REG), (m_status == 3'(mrc_pkg::ST_OK)) && (m_exception_code == 8'h00), "register word carries status fields")

    // Exception code only on exception status
    `MRC_ASSERT_SAME(a_exc_code, m_valid && (m_status != 3'(mrc_pkg::ST_EXCEPTION)), m_exception_code == 8'h00, "exception code without exception status")

endmodule

bind modbus_rtu_read_response_checker mrc_checker u_mrc_checker (.*);

// ===== tb/tb_modbus_rtu_read_response_checker.sv =====
`timescale 1ns / 100ps

module tb_modbus_rtu_read_response_checker;

    localparam int FRAME_LIMIT = 260;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int PHASE_BYTES = 90;
    localparam int SETTLE_CYCLES = 8;

    // Function codes of the read requests
    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FUNC_READ_INPUT   = 8'h04;

    typedef enum int {
        TAIL_GOOD,
        TAIL_CORRUPT,
        TAIL_NONE
    } tail_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } tx_byte_t;

    typedef struct packed {
        logic             kind;
        logic [6:0]       index;
        logic [15:0]      value;
        mrc_pkg::status_t status;
        logic [7:0]       exc;
        logic             last;
    } result_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_in = 8'h00;
    logic        s_end_of_frame = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [6:0]  m_reg_index;
    logic [15:0] m_reg_value;
    logic [2:0]  m_status;
    logic [7:0]  m_exception_code;
    logic        m_last;

    // Bytes waiting to be sent and words waiting to be received
    tx_byte_t     tx_bytes[$];
    result_word_t expected_words[$];
    logic [7:0]   frame_buf[$];

    int errors = 0;
    int queued_total = 0;
    int quiet_cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_cnt = 0;
    bit idle_on = 1'b1;
    bit send_pause = 1'b0;
    bit hold_req = 1'b0;
    logic [7:0] cur_func = FUNC_READ_HOLDING;
    tx_byte_t next_byte;

    // Response parser state
    logic [7:0] want_func;
    logic [7:0] fr_prev0;
    logic [7:0] fr_prev1;
    logic [15:0] fr_crc;
    logic [8:0] fr_pos;
    logic [7:0] fr_func;
    logic [7:0] fr_count;
    logic [7:0] fr_high;
    logic [6:0] fr_regs;

    modbus_rtu_read_response_checker #(
        .MAX_FRAME(FRAME_LIMIT)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_byte_in(s_byte_in),
        .s_end_of_frame(s_end_of_frame),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_reg_index(m_reg_index),
        .m_reg_value(m_reg_value),
        .m_status(m_status),
        .m_exception_code(m_exception_code),
        .m_last(m_last)
    );

    always #5 aclk = ~aclk;

    // Bitwise CRC-16, data bit folded in at the feedback point
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[k]) begin
                c = {1'b0, c[15:1]} ^ mrc_pkg::CRC_POLY;
            end else begin
                c = {1'b0, c[15:1]};
            end
        end
        return c;
    endfunction

    task automatic clear_frame();
        fr_prev0 = 8'h00;
        fr_prev1 = 8'h00;
        fr_crc = mrc_pkg::CRC_INIT;
        fr_pos = '0;
        fr_func = 8'h00;
        fr_count = 8'h00;
        fr_high = 8'h00;
        fr_regs = '0;
    endtask

    // Advance the parser by one byte and queue the words it should produce
    task automatic parse_response_byte(input logic [7:0] b, input logic eof);
        result_word_t w;
        int frame_len;
        logic [15:0] rx_crc;
        if (fr_pos >= 2) begin
            fr_crc = crc16_step(fr_crc, fr_prev1);
        end
        if (fr_pos < FRAME_LIMIT) begin
            if (fr_pos == 1) begin
                fr_func = b;
            end else if (fr_pos == 2) begin
                fr_count = b;
            end else if (fr_pos >= 3 && fr_pos[0]) begin
                fr_high = b;
            end else if (fr_pos >= 4 && int'(fr_pos) <= int'(fr_count) + 2) begin
                w.kind = mrc_pkg::KIND_REG;
                w.index = fr_regs;
                w.value = {fr_high, b};
                w.status = mrc_pkg::ST_OK;
                w.exc = 8'h00;
                w.last = 1'b0;
                expected_words.push_back(w);
                fr_regs = fr_regs + 7'd1;
            end
        end
        if (eof) begin
            frame_len = int'(fr_pos) + 1;
            rx_crc = {b, fr_prev0};
            w.kind = mrc_pkg::KIND_STATUS;
            w.index = '0;
            w.value = '0;
            w.exc = 8'h00;
            w.last = 1'b1;
            if (frame_len < 5) begin
                w.status = mrc_pkg::ST_SHORT;
            end else if (fr_crc != rx_crc) begin
                w.status = mrc_pkg::ST_CRC;
            end else if (fr_func == (want_func | mrc_pkg::EXC_FLAG)) begin
                w.status = mrc_pkg::ST_EXCEPTION;
                w.exc = fr_count;
            end else if (fr_func != want_func) begin
                w.status = mrc_pkg::ST_BAD_FUNC;
            end else if (fr_count == 0 || fr_pos >= FRAME_LIMIT
                         || frame_len != int'(fr_count) + 5) begin
                w.status = mrc_pkg::ST_BAD_COUNT;
            end else if (fr_count[0]) begin
                w.status = mrc_pkg::ST_ODD_COUNT;
            end else begin
                w.status = mrc_pkg::ST_OK;
            end
            expected_words.push_back(w);
            clear_frame();
        end else begin
            fr_prev1 = fr_prev0;
            fr_prev0 = b;
            if (fr_pos < FRAME_LIMIT) begin
                fr_pos = fr_pos + 9'd1;
            end
        end
    endtask

    // Check outgoing words, then track config writes and accepted bytes
    always @(posedge aclk) begin
        if (!aresetn) begin
            want_func = FUNC_READ_HOLDING;
            clear_frame();
            expected_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word kind %0d index %0d value %h",
                             $time, m_kind, m_reg_index, m_reg_value,
                             " status %0d exc %h last %0d",
                             m_status, m_exception_code, m_last);
                    errors++;
                end else if (m_kind !== expected_words[0].kind
                             || m_reg_index !== expected_words[0].index
                             || m_reg_value !== expected_words[0].value
                             || m_status !== expected_words[0].status
                             || m_exception_code !== expected_words[0].exc
                             || m_last !== expected_words[0].last) begin
                    $display("%0t: word mismatch, expected kind %0d index %0d value %h",
                             $time, expected_words[0].kind, expected_words[0].index,
                             expected_words[0].value,
                             " status %0d exc %h last %0d;",
                             expected_words[0].status, expected_words[0].exc,
                             expected_words[0].last,
                             " got kind %0d index %0d value %h",
                             m_kind, m_reg_index, m_reg_value,
                             " status %0d exc %h last %0d",
                             m_status, m_exception_code, m_last);
                    errors++;
                    void'(expected_words.pop_front());
                end else begin
                    void'(expected_words.pop_front());
                end
            end
            if (cfg_valid && cfg_ready) begin
                want_func = cfg_data;
            end
            if (s_valid && s_ready) begin
                parse_response_byte(s_byte_in, s_end_of_frame);
            end
        end
    end

    // Send bytes from the queue, with random gaps; hold a word until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else if (!(s_valid && !s_ready)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (tx_bytes.size() == 0 || send_pause) begin
                s_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                send_gap = int'($urandom_range(0, 7));
                s_valid <= 1'b0;
            end else begin
                next_byte = tx_bytes.pop_front();
                s_byte_in <= next_byte.data;
                s_end_of_frame <= next_byte.eof;
                s_valid <= 1'b1;
            end
        end
    end

    // Drive ready with random stalls and the occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap = 0;
            hold_cnt = 0;
        end else begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_OFF_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                recv_gap = int'($urandom_range(0, 7));
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_modbus_rtu_read_response_checker failed");
                $finish;
            end
        end
    end

    // Append the CRC as asked and queue the frame buffer byte by byte
    task automatic emit_frame(input tail_t tail);
        logic [15:0] crc;
        tx_byte_t w;
        crc = mrc_pkg::CRC_INIT;
        if (tail != TAIL_NONE) begin
            foreach (frame_buf[i]) begin
                crc = crc16_step(crc, frame_buf[i]);
            end
            if (tail == TAIL_CORRUPT) begin
                crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            end
            frame_buf.push_back(crc[7:0]);
            frame_buf.push_back(crc[15:8]);
        end
        foreach (frame_buf[i]) begin
            w.data = frame_buf[i];
            w.eof = (i == frame_buf.size() - 1);
            tx_bytes.push_back(w);
        end
        queued_total += frame_buf.size();
        frame_buf.delete();
    endtask

    // Long response with a good CRC and the given byte count and data length
    task automatic queue_long_frame(input int count, input int data_len);
        frame_buf.delete();
        frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf.push_back(cur_func);
        frame_buf.push_back(8'(count));
        repeat (data_len) frame_buf.push_back(8'($urandom_range(0, 255)));
        emit_frame(TAIL_GOOD);
    endtask

    // Mostly well-formed responses with random content, some broken, some noise
    task automatic queue_random_frame();
        int count;
        int data_len;
        logic [7:0] func;
        frame_buf.delete();
        if ($urandom_range(0, 19) < 2) begin
            repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom_range(0, 255)));
            emit_frame(TAIL_NONE);
        end else begin
            case ($urandom_range(0, 9))
                7: func = cur_func | mrc_pkg::EXC_FLAG;
                8: func = 8'($urandom_range(0, 255));
                9: func = cur_func ^ (8'h01 << $urandom_range(0, 7));
                default: func = cur_func;
            endcase
            case ($urandom_range(0, 9))
                7: count = 2 * int'($urandom_range(0, 11)) + 1;
                8: count = 0;
                9: count = int'($urandom_range(0, 40));
                default: count = 2 * int'($urandom_range(1, 12));
            endcase
            data_len = count;
            if ($urandom_range(0, 7) == 0) begin
                data_len = count + int'($urandom_range(0, 6)) - 3;
                if (data_len < 0) begin
                    data_len = 0;
                end
            end
            frame_buf.push_back(8'($urandom_range(0, 255)));
            frame_buf.push_back(func);
            frame_buf.push_back(8'(count));
            repeat (data_len) frame_buf.push_back(8'($urandom_range(0, 255)));
            emit_frame($urandom_range(0, 9) == 0 ? TAIL_CORRUPT : TAIL_GOOD);
        end
    endtask

    // Wait until every byte is in and every word is out, then let the block settle
    task automatic wait_drained();
        do @(negedge aclk); while (tx_bytes.size() != 0 || s_valid
                                   || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_function_code(input logic [7:0] code);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= code;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_func = code;
        @(negedge aclk);
    endtask

    initial begin
        logic [7:0] codes[5];
        int phase_start;
        int half_left;
        codes = '{FUNC_READ_HOLDING, FUNC_READ_INPUT, 8'h00, 8'hFF, FUNC_READ_HOLDING};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // well-formed response, registers at both value extremes
        frame_buf = '{8'h01, FUNC_READ_HOLDING, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
        emit_frame(TAIL_GOOD);
        // lone byte and four bytes: both too short
        frame_buf = '{8'h5A};
        emit_frame(TAIL_NONE);
        frame_buf = '{8'h01, FUNC_READ_HOLDING, 8'h02, 8'hFF};
        emit_frame(TAIL_NONE);
        // exception response
        frame_buf = '{8'h01, FUNC_READ_HOLDING | mrc_pkg::EXC_FLAG, 8'h02};
        emit_frame(TAIL_GOOD);
        // input-register function while holding registers were asked
        frame_buf = '{8'h01, FUNC_READ_INPUT, 8'h02, 8'h12, 8'h34};
        emit_frame(TAIL_GOOD);
        // zero byte count
        frame_buf = '{8'h01, FUNC_READ_HOLDING, 8'h00};
        emit_frame(TAIL_GOOD);
        // damaged CRC
        frame_buf = '{8'h01, FUNC_READ_HOLDING, 8'h02, 8'hAB, 8'hCD};
        emit_frame(TAIL_CORRUPT);
        // odd byte count
        frame_buf = '{8'h01, FUNC_READ_HOLDING, 8'h01, 8'h7F};
        emit_frame(TAIL_GOOD);
        // count larger than the frame: the closing byte completes a pair
        frame_buf = '{8'h01, FUNC_READ_HOLDING, 8'h0A, 8'h11, 8'h22};
        emit_frame(TAIL_GOOD);

        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            write_function_code(codes[ph]);
            idle_on = (ph != 4);
            phase_start = queued_total;
            if (ph == 0) begin
                // largest well-formed response
                queue_long_frame(254, 254);
            end
            if (ph == 2) begin
                // response past the frame limit
                queue_long_frame(255, 258);
            end
            while (queued_total - phase_start < PHASE_BYTES) begin
                queue_random_frame();
            end
            if (ph == 1) begin
                hold_req = 1'b1;
            end
            if (ph == 3) begin
                half_left = tx_bytes.size() / 2;
                do @(negedge aclk); while (tx_bytes.size() > half_left);
                send_pause = 1'b1;
                do @(negedge aclk); while (s_valid || expected_words.size() != 0);
                send_pause = 1'b0;
            end
        end

        wait_drained();
        if (errors == 0) begin
            $display("tb_modbus_rtu_read_response_checker passed");
        end else begin
            $display("tb_modbus_rtu_read_response_checker failed");
        end
        $finish;
    end

endmodule
